>>> rtl/dma4_pkg.sv
// shared types, codes and constants of the four-channel dma controller
package dma4_pkg;

  // default parameter values
  localparam int CHANNELS_DEF   = 4;
  localparam int START_WAIT_DEF = 2;

  // operation codes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // register map
  localparam logic [7:0] REG_BASE = 8'hB0;
  localparam int         REG_SPAN = 12;

  localparam logic [1:0] LOC_GRP_SRC = 2'd0;
  localparam logic [1:0] LOC_GRP_DST = 2'd1;
  localparam logic [3:0] LOC_CNT_LO  = 4'd8;
  localparam logic [3:0] LOC_CNT_HI  = 4'd9;
  localparam logic [3:0] LOC_CTRL_LO = 4'd10;
  localparam logic [3:0] LOC_CTRL_HI = 4'd11;

  // address stepping controls
  localparam logic [1:0] SRC_INC   = 2'd0;
  localparam logic [1:0] SRC_DEC   = 2'd1;
  localparam logic [1:0] DST_DEC   = 2'd1;
  localparam logic [1:0] DST_FIXED = 2'd2;

  // start timing: immediate
  localparam logic [1:0] TIMING_NOW = 2'd0;

  function automatic logic [27:0] src_mask(input int ch);
    return (ch == 0) ? 28'h7FF_FFFF : 28'hFFF_FFFF;
  endfunction

  function automatic logic [27:0] dst_mask(input int ch);
    return (ch == 3) ? 28'hFFF_FFFF : 28'h7FF_FFFF;
  endfunction

  function automatic logic [15:0] cnt_mask(input int ch);
    return (ch == 3) ? 16'hFFFF : 16'h3FFF;
  endfunction

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] reg_offset;
    logic [7:0] write_data;
    logic [7:0] tick_cycles;
  } dma4_item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        reg_error;
    logic        transfer_valid;
    logic [1:0]  channel;
    logic [31:0] src_address;
    logic [31:0] dst_address;
    logic        word_size;
    logic        burst_last;
    logic        irq_pulse;
  } dma4_result_t;

  // strobes and data from the decode into one channel
  typedef struct packed {
    logic       wr;
    logic       tick;
    logic       grant;
    logic [3:0] loc;
    logic [7:0] data;
    logic [7:0] cyc;
  } dma4_chan_cmd_t;

  // channel status seen by the arbiter and the result mux
  typedef struct packed {
    logic        run;
    logic [10:0] ctrl;
    logic [31:0] src;
    logic [31:0] dst;
    logic        xfer;
    logic        last;
  } dma4_chan_sts_t;

endpackage

>>> rtl/dma4_if.sv
// valid/ready channel interfaces for words in and results out

interface dma4_in_if;
  logic                  valid;
  logic                  ready;
  dma4_pkg::dma4_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dma4_out_if;
  logic                   valid;
  logic                   ready;
  dma4_pkg::dma4_result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/dma4_chan.sv
// one dma channel: registers, start wait, cursors and unit count
module dma4_chan #(
  parameter int CH_INDEX   = 0,
  parameter int START_WAIT = dma4_pkg::START_WAIT_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  dma4_pkg::dma4_chan_cmd_t cmd,
  output dma4_pkg::dma4_chan_sts_t sts
);

  localparam logic [27:0] SRC_MASK   = dma4_pkg::src_mask(CH_INDEX);
  localparam logic [27:0] DST_MASK   = dma4_pkg::dst_mask(CH_INDEX);
  localparam logic [15:0] CNT_MASK   = dma4_pkg::cnt_mask(CH_INDEX);
  localparam logic [16:0] UNITS_FULL = {1'b0, CNT_MASK} + 17'd1;
  localparam logic [1:0]  WAIT_INIT  = 2'(START_WAIT);

  logic [27:0] src_base_r, src_base_nxt;
  logic [27:0] dst_base_r, dst_base_nxt;
  logic [15:0] count_r,    count_nxt;
  logic [10:0] ctrl_r,     ctrl_nxt;
  logic [31:0] src_cur_r,  src_cur_nxt;
  logic [31:0] dst_cur_r,  dst_cur_nxt;
  logic [16:0] units_r,    units_nxt;
  logic [1:0]  delay_r,    delay_nxt;
  logic        active_r,   active_nxt;

  logic        start_now;
  logic [31:0] amt;
  logic [31:0] wide32;
  logic [15:0] cnt16;

  // start wait expires on this tick
  assign start_now = (delay_r != 2'd0) && ({6'd0, delay_r} <= cmd.cyc);
  assign amt       = ctrl_r[5] ? 32'd4 : 32'd2;

  assign sts.run  = active_r || start_now;
  assign sts.ctrl = ctrl_r;
  assign sts.src  = src_cur_r;
  assign sts.dst  = dst_cur_r;
  assign sts.xfer = (units_r != 17'd0);
  assign sts.last = (units_r <= 17'd1);

  always_comb begin
    src_base_nxt = src_base_r;
    dst_base_nxt = dst_base_r;
    count_nxt    = count_r;
    ctrl_nxt     = ctrl_r;
    src_cur_nxt  = src_cur_r;
    dst_cur_nxt  = dst_cur_r;
    units_nxt    = units_r;
    delay_nxt    = delay_r;
    active_nxt   = active_r;
    wide32       = 32'd0;
    cnt16        = count_r;

    if (cmd.wr) begin
      if (cmd.loc[3:2] == dma4_pkg::LOC_GRP_SRC) begin
        wide32 = {4'd0, src_base_r};
        wide32[{cmd.loc[1:0], 3'd0} +: 8] = cmd.data;
        src_base_nxt = wide32[27:0] & SRC_MASK;
      end else if (cmd.loc[3:2] == dma4_pkg::LOC_GRP_DST) begin
        wide32 = {4'd0, dst_base_r};
        wide32[{cmd.loc[1:0], 3'd0} +: 8] = cmd.data;
        dst_base_nxt = wide32[27:0] & DST_MASK;
      end else begin
        case (cmd.loc)
          dma4_pkg::LOC_CNT_LO: begin
            cnt16[7:0] = cmd.data;
            count_nxt  = cnt16 & CNT_MASK;
          end
          dma4_pkg::LOC_CNT_HI: begin
            cnt16[15:8] = cmd.data;
            count_nxt   = cnt16 & CNT_MASK;
          end
          dma4_pkg::LOC_CTRL_LO: begin
            ctrl_nxt[2:0] = cmd.data[7:5];
          end
          default: begin
            // high control byte; bit 3 is not stored
            ctrl_nxt = {cmd.data[7:4], 1'b0, cmd.data[2:0], ctrl_r[2:0]};
            if (!ctrl_r[10] && cmd.data[7]) begin
              src_cur_nxt = {4'd0, src_base_r};
              dst_cur_nxt = {4'd0, dst_base_r};
              units_nxt   = (count_r == 16'd0) ? UNITS_FULL : {1'b0, count_r};
            end
            if (cmd.data[7] && (cmd.data[5:4] == dma4_pkg::TIMING_NOW)) begin
              delay_nxt  = WAIT_INIT;
              active_nxt = (WAIT_INIT == 2'd0);
            end else begin
              delay_nxt  = 2'd0;
              active_nxt = 1'b0;
            end
          end
        endcase
      end
    end else if (cmd.tick) begin
      if (delay_r != 2'd0) begin
        if (start_now) begin
          delay_nxt  = 2'd0;
          active_nxt = 1'b1;
        end else begin
          delay_nxt = delay_r - cmd.cyc[1:0];
        end
      end
      if (cmd.grant) begin
        if (units_r != 17'd0) begin
          case (ctrl_r[3:2])
            dma4_pkg::SRC_INC: src_cur_nxt = src_cur_r + amt;
            dma4_pkg::SRC_DEC: src_cur_nxt = src_cur_r - amt;
            default:           src_cur_nxt = src_cur_r;
          endcase
          case (ctrl_r[1:0])
            dma4_pkg::DST_DEC:   dst_cur_nxt = dst_cur_r - amt;
            dma4_pkg::DST_FIXED: dst_cur_nxt = dst_cur_r;
            default:             dst_cur_nxt = dst_cur_r + amt;
          endcase
          units_nxt = units_r - 17'd1;
        end
        if (units_r <= 17'd1) begin
          active_nxt   = 1'b0;
          ctrl_nxt[10] = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_base_r <= '0;
      dst_base_r <= '0;
      count_r    <= '0;
      ctrl_r     <= '0;
      src_cur_r  <= '0;
      dst_cur_r  <= '0;
      units_r    <= '0;
      delay_r    <= '0;
      active_r   <= 1'b0;
    end else begin
      src_base_r <= src_base_nxt;
      dst_base_r <= dst_base_nxt;
      count_r    <= count_nxt;
      ctrl_r     <= ctrl_nxt;
      src_cur_r  <= src_cur_nxt;
      dst_cur_r  <= dst_cur_nxt;
      units_r    <= units_nxt;
      delay_r    <= delay_nxt;
      active_r   <= active_nxt;
    end
  end

endmodule

>>> rtl/dma4_arb.sv
// fixed-priority pick of the lowest running channel
module dma4_arb #(
  parameter int CHANNELS = dma4_pkg::CHANNELS_DEF
) (
  input  logic [CHANNELS-1:0] req,
  output logic                any,
  output logic [1:0]          idx,
  output logic [CHANNELS-1:0] gnt
);

  always_comb begin
    any = 1'b0;
    idx = 2'd0;
    gnt = '0;
    // walk down so the lowest requester wins
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      if (req[i]) begin
        any = 1'b1;
        idx = 2'(i);
        gnt = '0;
        gnt[i] = 1'b1;
      end
    end
  end

endmodule

>>> rtl/four_channel_dma_controller_top.sv
// top level of the four-channel dma controller: decode, channels, result register
//
//  channel  | dir | handshake      | word
//  ---------+-----+----------------+-------------------------------------------
//  in_bus   | in  | valid / ready  | operation, reg_offset, write_data, ticks
//  out_bus  | out | valid / ready  | read data, error, one transfer command
//
// one word per cycle sustained while the result register can drain; a word taken
// into the input register goes through one decode pass into the result register
// the input register stalls only while the result register is full and
// out_bus.ready is low, so in_bus.ready falls only then
// rst_n is synchronous, active low, and clears every channel register
module four_channel_dma_controller_top #(
  parameter int CHANNELS   = dma4_pkg::CHANNELS_DEF,
  parameter int START_WAIT = dma4_pkg::START_WAIT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  dma4_in_if.sink     in_bus,
  dma4_out_if.source  out_bus
);

  // end of the channel register window
  localparam logic [8:0] REG_END = 9'(int'(dma4_pkg::REG_BASE) + dma4_pkg::REG_SPAN * CHANNELS);

  // input stage
  logic                 in_v_r;
  dma4_pkg::dma4_item_t in_item_r;

  // result stage
  logic                   out_v_r;
  dma4_pkg::dma4_result_t out_res_r, out_res_nxt;

  logic adv;

  // offset decode
  logic [7:0] rel;
  logic [7:0] ch_base;
  logic [1:0] ch_sel;
  logic [3:0] loc;
  logic       in_range;

  dma4_pkg::dma4_chan_cmd_t cmd [CHANNELS];
  dma4_pkg::dma4_chan_sts_t sts [CHANNELS];

  logic [CHANNELS-1:0] run_req;
  logic [CHANNELS-1:0] gnt;
  logic                any_run;
  logic [1:0]          gnt_idx;

  // the word in the input register moves on whenever the result slot frees
  assign adv          = in_v_r && (!out_v_r || out_bus.ready);
  assign in_bus.ready = !in_v_r || adv;

  assign out_bus.valid = out_v_r;
  assign out_bus.data  = out_res_r;

  // channel and byte within channel, twelve bytes per channel
  always_comb begin
    rel = in_item_r.reg_offset - dma4_pkg::REG_BASE;
    if (rel >= 8'(3 * dma4_pkg::REG_SPAN)) begin
      ch_sel  = 2'd3;
      ch_base = 8'(3 * dma4_pkg::REG_SPAN);
    end else if (rel >= 8'(2 * dma4_pkg::REG_SPAN)) begin
      ch_sel  = 2'd2;
      ch_base = 8'(2 * dma4_pkg::REG_SPAN);
    end else if (rel >= 8'(dma4_pkg::REG_SPAN)) begin
      ch_sel  = 2'd1;
      ch_base = 8'(dma4_pkg::REG_SPAN);
    end else begin
      ch_sel  = 2'd0;
      ch_base = 8'd0;
    end
    loc      = 4'(rel - ch_base);
    in_range = (in_item_r.reg_offset >= dma4_pkg::REG_BASE) &&
               ({1'b0, in_item_r.reg_offset} < REG_END);
  end

  // channels
  for (genvar g = 0; g < CHANNELS; g++) begin : g_chan
    always_comb begin
      cmd[g].wr    = adv && (in_item_r.operation == dma4_pkg::OP_WRITE) && in_range &&
                     (ch_sel == 2'(g));
      cmd[g].tick  = adv && (in_item_r.operation == dma4_pkg::OP_TICK);
      cmd[g].grant = adv && (in_item_r.operation == dma4_pkg::OP_TICK) && gnt[g];
      cmd[g].loc   = loc;
      cmd[g].data  = in_item_r.write_data;
      cmd[g].cyc   = in_item_r.tick_cycles;
    end

    assign run_req[g] = sts[g].run;

    dma4_chan #(
      .CH_INDEX   (g),
      .START_WAIT (START_WAIT)
    ) u_chan (
      .clk   (clk),
      .rst_n (rst_n),
      .cmd   (cmd[g]),
      .sts   (sts[g])
    );
  end

  dma4_arb #(
    .CHANNELS (CHANNELS)
  ) u_arb (
    .req (run_req),
    .any (any_run),
    .idx (gnt_idx),
    .gnt (gnt)
  );

  // result of the word in the input register
  always_comb begin
    out_res_nxt = '0;
    case (in_item_r.operation)
      dma4_pkg::OP_WRITE, dma4_pkg::OP_READ: begin
        if (!in_range) begin
          out_res_nxt.reg_error = 1'b1;
        end else if (in_item_r.operation == dma4_pkg::OP_READ) begin
          for (int i = 0; i < CHANNELS; i++) begin
            if (ch_sel == 2'(i)) begin
              if (loc == dma4_pkg::LOC_CTRL_LO) begin
                out_res_nxt.read_data = {sts[i].ctrl[2:0], 5'd0};
              end else if (loc == dma4_pkg::LOC_CTRL_HI) begin
                out_res_nxt.read_data = {sts[i].ctrl[10:7], 1'b0, sts[i].ctrl[5:3]};
              end
            end
          end
        end
      end
      dma4_pkg::OP_TICK: begin
        if (any_run) begin
          out_res_nxt.channel = gnt_idx;
          for (int i = 0; i < CHANNELS; i++) begin
            if (gnt[i]) begin
              out_res_nxt.transfer_valid = sts[i].xfer;
              // addresses and size only go out with a real transfer
              if (sts[i].xfer) begin
                out_res_nxt.src_address = sts[i].src;
                out_res_nxt.dst_address = sts[i].dst;
                out_res_nxt.word_size   = sts[i].ctrl[5];
              end
              out_res_nxt.burst_last = sts[i].last;
              out_res_nxt.irq_pulse  = sts[i].last && sts[i].ctrl[9];
            end
          end
        end
      end
      default: begin
        out_res_nxt = '0;
      end
    endcase
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_bus.valid && in_bus.ready) begin
      in_v_r <= 1'b1;
    end else if (adv) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      in_item_r <= in_bus.data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= out_res_nxt;
    end
  end

  // at most one channel granted
  a_gnt_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(gnt))
    else $error("more than one channel granted");

  // a transfer command only comes from a tick word
  a_xfer_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
    adv && (in_item_r.operation != dma4_pkg::OP_TICK) |=> !out_res_r.transfer_valid)
    else $error("transfer command from a register access");

  // the interrupt only comes with the end of a burst
  a_irq_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_res_r.irq_pulse |-> out_res_r.burst_last)
    else $error("irq without burst end");

  // a stalled input word stays put
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !adv |=> in_v_r && $stable(in_item_r))
    else $error("input register lost a stalled word");

endmodule
